// File: hdl/ple_pkg.sv
// ple_pkg: shared constants, request and status codes, and the cell and tree
// record types of the positional list engine
// no dependencies; imported by every module of the engine
`default_nettype none

package ple_pkg;

    // list capacity and derived widths
    localparam int DEPTH  = 512;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths of the stream payload
    localparam int REQ_W  = 3;
    localparam int POS_W  = 9;
    localparam int KEY_W  = 64;
    localparam int AGE_W  = 8;
    localparam int STAT_W = 2;
    localparam int OIDX_W = 9;
    localparam int OCNT_W = 10;

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = STAT_W;

    // width wide enough to compare a position with the count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // registered selection tree, eight children per node
    localparam int RADIX       = 8;
    localparam int TREE_LVL    = (IDX_W + 2) / 3;
    localparam int TREE_LEAVES = RADIX ** TREE_LVL;
    localparam int LVL_W       = $clog2(TREE_LVL + 1);

    // number of nodes on a tree level (level 1 sits just above the leaves)
    function automatic int lvl_size(int lv);
        return RADIX ** (TREE_LVL - lv);
    endfunction

    // first slot of a tree level in the flat node store
    function automatic int lvl_off(int lv);
        int acc;
        acc = 0;
        for (int k = 1; k < lv; k++) begin
            acc = acc + lvl_size(k);
        end
        return acc;
    endfunction

    localparam int TREE_NODES = lvl_off(TREE_LVL + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT     = 3'd0,
        REQ_DELETE     = 3'd1,
        REQ_READ_FRONT = 3'd2,
        REQ_READ_BACK  = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_CLEAR      = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // one candidate entry travelling up the selection tree
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } node_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             shift_up;
        logic             shift_dn;
        logic             find_key;
        logic [IDX_W-1:0] tgt;
        logic [CNT_W-1:0] cnt;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } ctrl_t;

endpackage

`default_nettype wire

// File: hdl/ple_cell.sv
// ple_cell: one list slot holding a key and an age, shifting to or from its
// neighbours and flagging itself for the selection tree
// depends on ple_pkg
`default_nettype none

module ple_cell (
    input  logic                         aclk,
    input  logic [ple_pkg::IDX_W-1:0]    cell_idx,
    input  ple_pkg::ctrl_t               ctrl_i,
    input  logic [ple_pkg::KEY_W-1:0]    left_key_i,
    input  logic [ple_pkg::AGE_W-1:0]    left_age_i,
    input  logic [ple_pkg::KEY_W-1:0]    right_key_i,
    input  logic [ple_pkg::AGE_W-1:0]    right_age_i,
    output logic [ple_pkg::KEY_W-1:0]    key_o,
    output logic [ple_pkg::AGE_W-1:0]    age_o,
    output ple_pkg::node_t               node_o
);
    import ple_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             hit;

    // insert: slots above the target take the left neighbour, target takes the new entry
    // delete: slots from the target up take the right neighbour
    always_comb begin
        key_next = key_reg;
        age_next = age_reg;
        if (ctrl_i.shift_up) begin
            if (cell_idx > ctrl_i.tgt) begin
                key_next = left_key_i;
                age_next = left_age_i;
            end else if (cell_idx == ctrl_i.tgt) begin
                key_next = ctrl_i.key;
                age_next = ctrl_i.age;
            end
        end else if (ctrl_i.shift_dn) begin
            if (cell_idx >= ctrl_i.tgt) begin
                key_next = right_key_i;
                age_next = right_age_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        age_reg <= age_next;
    end

    // key match inside the live part of the list, or the addressed slot
    always_comb begin
        if (ctrl_i.find_key) begin
            hit = (key_reg == ctrl_i.key) && (CNT_W'(cell_idx) < ctrl_i.cnt);
        end else begin
            hit = (cell_idx == ctrl_i.tgt);
        end
    end

    assign key_o      = key_reg;
    assign age_o      = age_reg;
    assign node_o.hit = hit;
    assign node_o.idx = cell_idx;
    assign node_o.key = key_reg;
    assign node_o.age = age_reg;

endmodule

`default_nettype wire

// File: hdl/ple_tree.sv
// ple_tree: registered eight-way selection tree that returns the flagged
// cell with the highest index, one tree level per cycle
// depends on ple_pkg
`default_nettype none

module ple_tree (
    input  logic            aclk,
    input  ple_pkg::node_t  leaf_i [ple_pkg::DEPTH],
    output ple_pkg::node_t  root_o
);
    import ple_pkg::*;

    node_t leaf_pad  [TREE_LEAVES];
    node_t node_reg  [TREE_NODES];
    node_t node_next [TREE_NODES];

    // pad the leaf row to a whole power of the radix
    for (genvar g = 0; g < TREE_LEAVES; g++) begin : g_pad
        if (g < DEPTH) begin : g_real
            assign leaf_pad[g] = leaf_i[g];
        end else begin : g_fill
            assign leaf_pad[g] = '0;
        end
    end

    // each node keeps the highest-numbered child that is flagged
    for (genvar lv = 1; lv <= TREE_LVL; lv++) begin : g_lvl
        for (genvar n = 0; n < lvl_size(lv); n++) begin : g_node
            node_t kids [RADIX];
            node_t pick;

            for (genvar c = 0; c < RADIX; c++) begin : g_kid
                if (lv == 1) begin : g_from_leaf
                    assign kids[c] = leaf_pad[n*RADIX + c];
                end else begin : g_from_node
                    assign kids[c] = node_reg[lvl_off(lv-1) + n*RADIX + c];
                end
            end

            always_comb begin
                pick = kids[0];
                for (int c = 1; c < RADIX; c++) begin
                    if (kids[c].hit) begin
                        pick = kids[c];
                    end
                end
            end

            assign node_next[lvl_off(lv) + n] = pick;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
    end

    assign root_o = node_reg[TREE_NODES-1];

endmodule

`default_nettype wire

// File: hdl/positional_list_engine_core.sv
// positional_list_engine_core: ordered list held in a row of cells, with a
// sequencer, a registered selection tree and a result register
// depends on ple_pkg, ple_cell and ple_tree
// sequence: insert, clear and unused codes go from idle straight to the done state;
// delete, reads and search first walk one step per level of the registered
// selection tree; the done state loads the result once the result register is free
// one request at a time: a new request is taken the cycle after the previous
// result is loaded into the result register
// reset clears the entry count, the sequencer and the result valid; cell contents
// are left as they are
`default_nettype none

module positional_list_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,   // position, key, age, zero fill
    input  logic [ple_pkg::S_TUSER_W-1:0]   s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]   m_tdata,   // found_index, found_key, found_age,
                                                       // count, zero fill
    output logic [ple_pkg::M_TUSER_W-1:0]   m_tuser    // status
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [LVL_W-1:0]    walk_reg, walk_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    req_t                req_reg;
    logic [IDX_W-1:0]    tgt_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [AGE_W-1:0]    age_reg;
    logic                absent_reg;

    logic                m_valid_reg, m_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [OIDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [AGE_W-1:0]    out_age_reg, out_age_next;
    logic [OCNT_W-1:0]   out_cnt_reg, out_cnt_next;

    logic                s_fire;
    logic                done_fire;
    logic                full;
    logic [POS_W-1:0]    in_pos;
    logic [CMP_W-1:0]    pos_x, cnt_x;
    logic [IDX_W-1:0]    tgt_in;
    logic                absent_in;
    ctrl_t               ctrl;
    node_t               root;

    logic [KEY_W-1:0]    cell_key [DEPTH];
    logic [AGE_W-1:0]    cell_age [DEPTH];
    node_t               leaf     [DEPTH];

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign done_fire = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    assign full      = (count_reg == CNT_W'(DEPTH));

    // request decode at the handshake
    assign in_pos    = s_tdata[POS_W-1:0];
    assign pos_x     = CMP_W'(in_pos);
    assign cnt_x     = CMP_W'(count_reg);
    assign absent_in = (pos_x >= cnt_x);

    always_comb begin
        case (s_tuser)
            REQ_INSERT:    tgt_in = (pos_x > cnt_x) ? IDX_W'(count_reg) : IDX_W'(in_pos);
            REQ_READ_BACK: tgt_in = IDX_W'(cnt_x - pos_x - CMP_W'(1));
            default:       tgt_in = IDX_W'(in_pos);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg    <= req_t'(s_tuser);
            tgt_reg    <= tgt_in;
            key_reg    <= s_tdata[POS_W +: KEY_W];
            age_reg    <= s_tdata[POS_W+KEY_W +: AGE_W];
            absent_reg <= absent_in;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        walk_next  = walk_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    walk_next = LVL_W'(TREE_LVL - 1);
                    case (s_tuser)
                        REQ_DELETE, REQ_READ_FRONT, REQ_READ_BACK, REQ_SEARCH:
                            state_next = S_WALK;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    walk_next = walk_reg - LVL_W'(1);
                end
            end
            S_DONE: begin
                if (done_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // broadcast to the cells
    assign ctrl.shift_up = done_fire && (req_reg == REQ_INSERT) && !full;
    assign ctrl.shift_dn = done_fire && (req_reg == REQ_DELETE) && !absent_reg;
    assign ctrl.find_key = (req_reg == REQ_SEARCH);
    assign ctrl.tgt      = tgt_reg;
    assign ctrl.cnt      = count_reg;
    assign ctrl.key      = key_reg;
    assign ctrl.age      = age_reg;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0] lkey, rkey;
        logic [AGE_W-1:0] lage, rage;

        if (i == 0) begin : g_first
            assign lkey = '0;
            assign lage = '0;
        end else begin : g_inner_l
            assign lkey = cell_key[i-1];
            assign lage = cell_age[i-1];
        end

        if (i == DEPTH-1) begin : g_last
            assign rkey = '0;
            assign rage = '0;
        end else begin : g_inner_r
            assign rkey = cell_key[i+1];
            assign rage = cell_age[i+1];
        end

        ple_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(i)),
            .ctrl_i      (ctrl),
            .left_key_i  (lkey),
            .left_age_i  (lage),
            .right_key_i (rkey),
            .right_age_i (rage),
            .key_o       (cell_key[i]),
            .age_o       (cell_age[i]),
            .node_o      (leaf[i])
        );
    end

    ple_tree u_tree (
        .aclk   (aclk),
        .leaf_i (leaf),
        .root_o (root)
    );

    // result and count update
    always_comb begin
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_key_next    = out_key_reg;
        out_age_next    = out_age_reg;
        out_cnt_next    = out_cnt_reg;
        if (done_fire) begin
            m_valid_next    = 1'b1;
            out_status_next = ST_OK;
            out_idx_next    = '0;
            out_key_next    = '0;
            out_age_next    = '0;
            case (req_reg)
                REQ_INSERT: begin
                    if (full) begin
                        out_status_next = ST_FULL;
                    end else begin
                        count_next   = count_reg + CNT_W'(1);
                        out_idx_next = OIDX_W'(tgt_reg);
                        out_key_next = key_reg;
                        out_age_next = age_reg;
                    end
                end
                REQ_DELETE, REQ_READ_FRONT, REQ_READ_BACK: begin
                    if (absent_reg) begin
                        out_status_next = ST_ABSENT;
                    end else begin
                        if (req_reg == REQ_DELETE) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        out_idx_next = OIDX_W'(root.idx);
                        out_key_next = root.key;
                        out_age_next = root.age;
                    end
                end
                REQ_SEARCH: begin
                    if (root.hit) begin
                        out_idx_next = OIDX_W'(root.idx);
                        out_key_next = root.key;
                        out_age_next = root.age;
                    end else begin
                        out_status_next = ST_ABSENT;
                    end
                end
                REQ_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
            out_cnt_next = OCNT_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            walk_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_key_reg    <= out_key_next;
        out_age_reg    <= out_age_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W-OIDX_W-KEY_W-AGE_W-OCNT_W){1'b0}},
                       out_cnt_reg, out_age_reg, out_key_reg, out_idx_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond capacity");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg == ST_FULL) |-> full)
        else $error("full status reported with room in the list");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_up |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not raise the count by one");

    a_search_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && req_reg == REQ_SEARCH && root.hit) |->
        (root.key == key_reg))
        else $error("search hit with a different key");

endmodule

`default_nettype wire
